### hw/rtl/ctf_pkg.sv
package ctf_pkg;

    localparam int TUPLE_LIMIT_DEF = 1000;
    localparam int COPY_MAX_DEF    = 256;

    localparam logic [7:0] END_MARK = 8'hFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TUPLE_CODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBTUPLE_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUBTUPLE_CODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_BYTES     = 3'd4;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_TYPE,
        PH_LINK,
        PH_SUB,
        PH_SKIP,
        PH_COPY
    } phase_t;

    typedef enum logic [2:0] {
        OC_NONE,
        OC_NOT_FOUND,
        OC_EMPTY_FOUND,
        OC_DATA,
        OC_DATA_LAST
    } outcome_t;

    typedef struct packed {
        logic [7:0]  tuple_code;
        logic        subtuple_enable;
        logic [7:0]  subtuple_code;
        logic [8:0]  max_bytes;
        logic [15:0] space_bytes;
    } cfg_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] body_byte;
        logic       byte_valid;
        logic       last;
        logic       status;
    } result_t;

endpackage

### hw/rtl/ctf_walker.sv
module ctf_walker #(
    parameter int TUPLE_LIMIT = ctf_pkg::TUPLE_LIMIT_DEF,
    parameter int COPY_MAX    = ctf_pkg::COPY_MAX_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic             cmd,
    input  logic [7:0]       card_byte,
    input  ctf_pkg::cfg_t    cfg,
    output ctf_pkg::result_t result
);

    localparam logic [9:0] LIMIT_W   = 10'(TUPLE_LIMIT);
    localparam logic [8:0] COPY_CAP  = 9'(COPY_MAX);

    ctf_pkg::phase_t   phase_reg, phase_next;
    ctf_pkg::outcome_t outcome;

    logic [15:0] pos_reg, pos_next;
    logic [9:0]  ts_reg, ts_next;
    logic [7:0]  link_reg, link_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  copy_reg, copy_next;
    logic        tm_reg, tm_next;

    logic [15:0] pos_inc;
    logic        at_end_old;
    logic        at_end_new;
    logic [9:0]  ts_inc;
    logic [8:0]  cap;
    logic        hdr_go;
    logic        hdr_match;
    logic [7:0]  hdr_n;

    assign pos_inc    = pos_reg + 16'd1;
    assign at_end_old = (pos_reg >= cfg.space_bytes);
    assign at_end_new = (pos_inc >= cfg.space_bytes);
    assign ts_inc     = ts_reg + 10'd1;
    assign cap        = (cfg.max_bytes > COPY_CAP) ? COPY_CAP : cfg.max_bytes;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        ts_next    = ts_reg;
        link_next  = link_reg;
        left_next  = left_reg;
        copy_next  = copy_reg;
        tm_next    = tm_reg;
        outcome    = ctf_pkg::OC_NONE;
        hdr_go     = 1'b0;
        hdr_match  = 1'b0;
        hdr_n      = '0;
        if (!cmd)
        begin
            pos_next  = '0;
            ts_next   = '0;
            link_next = '0;
            left_next = '0;
            copy_next = '0;
            tm_next   = 1'b0;
            if (cfg.space_bytes == 16'd0)
            begin
                phase_next = ctf_pkg::PH_DONE;
                outcome    = ctf_pkg::OC_NOT_FOUND;
            end
            else
            begin
                phase_next = ctf_pkg::PH_TYPE;
            end
        end
        else if (phase_reg == ctf_pkg::PH_DONE || at_end_old)
        begin
            phase_next = ctf_pkg::PH_DONE;
        end
        else
        begin
            pos_next = pos_inc;
            unique case (phase_reg)
                ctf_pkg::PH_TYPE:
                begin
                    if (card_byte == ctf_pkg::END_MARK || at_end_new)
                    begin
                        phase_next = ctf_pkg::PH_DONE;
                        outcome    = ctf_pkg::OC_NOT_FOUND;
                    end
                    else
                    begin
                        tm_next    = (card_byte == cfg.tuple_code);
                        phase_next = ctf_pkg::PH_LINK;
                    end
                end
                ctf_pkg::PH_LINK:
                begin
                    if (card_byte == ctf_pkg::END_MARK)
                    begin
                        phase_next = ctf_pkg::PH_DONE;
                        outcome    = ctf_pkg::OC_NOT_FOUND;
                    end
                    else
                    begin
                        link_next = card_byte;
                        if (cfg.subtuple_enable && card_byte > 8'd1)
                        begin
                            if (at_end_new)
                            begin
                                phase_next = ctf_pkg::PH_DONE;
                                outcome    = ctf_pkg::OC_NOT_FOUND;
                            end
                            else
                            begin
                                phase_next = ctf_pkg::PH_SUB;
                            end
                        end
                        else
                        begin
                            hdr_go    = 1'b1;
                            hdr_match = tm_reg && !cfg.subtuple_enable;
                            hdr_n     = card_byte;
                        end
                    end
                end
                ctf_pkg::PH_SUB:
                begin
                    hdr_go    = 1'b1;
                    hdr_match = tm_reg && (card_byte == cfg.subtuple_code);
                    hdr_n     = link_reg - 8'd1;
                end
                ctf_pkg::PH_SKIP:
                begin
                    left_next = left_reg - 8'd1;
                    if (left_next == 8'd0)
                    begin
                        if (ts_reg >= LIMIT_W || at_end_new)
                        begin
                            phase_next = ctf_pkg::PH_DONE;
                            outcome    = ctf_pkg::OC_NOT_FOUND;
                        end
                        else
                        begin
                            phase_next = ctf_pkg::PH_TYPE;
                        end
                    end
                    else if (at_end_new)
                    begin
                        phase_next = ctf_pkg::PH_DONE;
                        outcome    = ctf_pkg::OC_NOT_FOUND;
                    end
                end
                ctf_pkg::PH_COPY:
                begin
                    copy_next = copy_reg - 8'd1;
                    if (copy_next == 8'd0 || at_end_new)
                    begin
                        phase_next = ctf_pkg::PH_DONE;
                        outcome    = ctf_pkg::OC_DATA_LAST;
                    end
                    else
                    begin
                        outcome = ctf_pkg::OC_DATA;
                    end
                end
                default:
                begin
                    phase_next = ctf_pkg::PH_DONE;
                end
            endcase

            // header complete: body length known, match decided
            if (hdr_go)
            begin
                if (hdr_match)
                begin
                    copy_next = (cap < {1'b0, hdr_n}) ? cap[7:0] : hdr_n;
                    if (copy_next == 8'd0 || at_end_new)
                    begin
                        phase_next = ctf_pkg::PH_DONE;
                        outcome    = ctf_pkg::OC_EMPTY_FOUND;
                    end
                    else
                    begin
                        phase_next = ctf_pkg::PH_COPY;
                    end
                end
                else
                begin
                    left_next = hdr_n;
                    ts_next   = ts_inc;
                    if (hdr_n == 8'd0)
                    begin
                        if (ts_inc >= LIMIT_W || at_end_new)
                        begin
                            phase_next = ctf_pkg::PH_DONE;
                            outcome    = ctf_pkg::OC_NOT_FOUND;
                        end
                        else
                        begin
                            phase_next = ctf_pkg::PH_TYPE;
                        end
                    end
                    else if (at_end_new)
                    begin
                        phase_next = ctf_pkg::PH_DONE;
                        outcome    = ctf_pkg::OC_NOT_FOUND;
                    end
                    else
                    begin
                        phase_next = ctf_pkg::PH_SKIP;
                    end
                end
            end
        end
    end

    always_comb
    begin
        result = '0;
        unique case (outcome)
            ctf_pkg::OC_NONE:
            begin
                result.emit = 1'b0;
            end
            ctf_pkg::OC_NOT_FOUND:
            begin
                result.emit   = 1'b1;
                result.last   = 1'b1;
                result.status = 1'b1;
            end
            ctf_pkg::OC_EMPTY_FOUND:
            begin
                result.emit = 1'b1;
                result.last = 1'b1;
            end
            ctf_pkg::OC_DATA:
            begin
                result.emit       = 1'b1;
                result.body_byte  = card_byte;
                result.byte_valid = 1'b1;
            end
            ctf_pkg::OC_DATA_LAST:
            begin
                result.emit       = 1'b1;
                result.body_byte  = card_byte;
                result.byte_valid = 1'b1;
                result.last       = 1'b1;
            end
            default:
            begin
                result.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ctf_pkg::PH_DONE;
            pos_reg   <= '0;
            ts_reg    <= '0;
            link_reg  <= '0;
            left_reg  <= '0;
            copy_reg  <= '0;
            tm_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ts_reg    <= ts_next;
            link_reg  <= link_next;
            left_reg  <= left_next;
            copy_reg  <= copy_next;
            tm_reg    <= tm_next;
        end
    end

    // copying always has a byte count left to deliver
    a_copy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ctf_pkg::PH_COPY |-> copy_reg != 8'd0)
        else $error("copy phase with zero count");

    // skipping always has a body byte left to skip
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ctf_pkg::PH_SKIP |-> left_reg != 8'd0)
        else $error("skip phase with zero count");

    // a byte taken while idle leaves the walker idle and silent
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && cmd && phase_reg == ctf_pkg::PH_DONE
        |-> !result.emit ##1 phase_reg == ctf_pkg::PH_DONE)
        else $error("idle walker reacted to a byte");

endmodule

### hw/rtl/cis_tuple_finder.sv
// Card information tuple finder.
// Program the search registers over the cfg channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data; cfg_ready is always high) while the block is idle.
// On the input channel (in_valid/in_stall) a request with cmd 0 starts a
// scan; requests with cmd 1 carry the card bytes from offset 0 in order.
// Each request that finishes a step of the walk may give one result on the
// output channel (out_valid/out_stall): a body byte of the matched tuple,
// or an end marker with last set and status 0 (found) or 1 (not found).
// A request passes through one input register and one result register.
// Throughput: one request per cycle while the receiver does not stall, set
// by the combinational compare and counter update of the walker.
// When the receiver stalls, the result register holds and the input
// register keeps the next request; in_stall rises only while both are full.
// Reset clears both registers, sets the walker to idle and loads the
// register defaults (max_bytes 256, all others 0).
module cis_tuple_finder #(
    parameter int TUPLE_LIMIT = ctf_pkg::TUPLE_LIMIT_DEF,
    parameter int COPY_MAX    = ctf_pkg::COPY_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ctf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [7:0]                     card_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     body_byte,
    output logic                           byte_valid,
    output logic                           last,
    output logic                           status
);

    ctf_pkg::cfg_t    cfg_reg;
    ctf_pkg::result_t res;

    logic       in_valid_reg;
    logic       cmd_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic [7:0] body_byte_reg;
    logic       byte_valid_reg;
    logic       last_reg;
    logic       status_reg;

    logic advance;
    logic step_en;
    logic in_fire;

    assign cfg_ready = 1'b1;
    assign advance   = !(out_valid_reg && out_stall);
    assign step_en   = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_fire   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tuple_code      <= '0;
            cfg_reg.subtuple_enable <= 1'b0;
            cfg_reg.subtuple_code   <= '0;
            cfg_reg.max_bytes       <= 9'd256;
            cfg_reg.space_bytes     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ctf_pkg::REG_TUPLE_CODE:      cfg_reg.tuple_code      <= cfg_data[7:0];
                ctf_pkg::REG_SUBTUPLE_ENABLE: cfg_reg.subtuple_enable <= cfg_data[0];
                ctf_pkg::REG_SUBTUPLE_CODE:   cfg_reg.subtuple_code   <= cfg_data[7:0];
                ctf_pkg::REG_MAX_BYTES:       cfg_reg.max_bytes       <= cfg_data[8:0];
                ctf_pkg::REG_SPACE_BYTES:     cfg_reg.space_bytes     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= cmd;
            byte_reg <= card_byte;
        end
    end

    ctf_walker #(
        .TUPLE_LIMIT (TUPLE_LIMIT),
        .COPY_MAX    (COPY_MAX)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .cmd       (cmd_reg),
        .card_byte (byte_reg),
        .cfg       (cfg_reg),
        .result    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step_en && res.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res.emit)
        begin
            body_byte_reg  <= res.body_byte;
            byte_valid_reg <= res.byte_valid;
            last_reg       <= res.last;
            status_reg     <= res.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign body_byte  = body_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign last       = last_reg;
    assign status     = status_reg;

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled without both registers full");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last)
        else $error("result without data is not final");

    a_notfound_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && !byte_valid && body_byte == 8'd0)
        else $error("not-found result carries data");

    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step_en))
        else $error("result appeared without a processed request");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int WALK_LIMIT = ctf_pkg::TUPLE_LIMIT_DEF;
    localparam int COPY_CAP   = ctf_pkg::COPY_MAX_DEF;
    localparam int RAND_ITEMS = 1600;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;
    localparam logic ST_FOUND  = 1'b0;
    localparam logic ST_MISS   = 1'b1;

    localparam logic [ctf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_SILENT,
        CHK_FIXED
    } chk_mode_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        logic [ctf_pkg::CFG_IDX_W-1:0]  idx;
        logic [ctf_pkg::CFG_DATA_W-1:0] val;
        logic                           c;
        chk_mode_t                      mode;
        ctf_pkg::result_t               fixed;
    } row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ctf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ctf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           cmd;
    logic [7:0]                     card_byte;
    logic                           out_valid;
    logic                           out_stall;
    logic [7:0]                     body_byte;
    logic                           byte_valid;
    logic                           last;
    logic                           status;

    cis_tuple_finder u_dut (.*);

    always #2 clk = ~clk;

    // shadow registers and walker state
    ctf_pkg::cfg_t    regs;
    ctf_pkg::phase_t  walk_phase;
    logic [15:0]      walk_pos;
    logic [9:0]       walk_seen;
    logic [7:0]       walk_link;
    logic [8:0]       walk_left;
    logic [8:0]       walk_copy;
    logic             walk_hit;
    bit               walk_ignored;
    int               walk_count;

    ctf_pkg::result_t pending[$];
    int               fail_count;
    int               gap_pct;
    int               stall_pct;
    int               stall_hold;
    chk_mode_t        req_mode;
    ctf_pkg::result_t req_fixed;
    row_t             dir_rows[$];

    function automatic bit space_used();
        return walk_pos >= regs.space_bytes;
    endfunction

    function automatic ctf_pkg::result_t make_result(logic [7:0] b, logic v, logic l,
                                                     logic s);
        ctf_pkg::result_t r;
        r = {1'b1, b, v, l, s};
        return r;
    endfunction

    function automatic ctf_pkg::result_t scan_miss();
        walk_phase = ctf_pkg::PH_DONE;
        return make_result(8'h00, 1'b0, 1'b1, ST_MISS);
    endfunction

    function automatic ctf_pkg::result_t next_tuple();
        if (walk_seen >= WALK_LIMIT || space_used())
            return scan_miss();
        walk_phase = ctf_pkg::PH_TYPE;
        return '0;
    endfunction

    function automatic ctf_pkg::result_t header_end(bit hit, logic [8:0] n);
        logic [8:0] c;
        if (hit)
        begin
            c = (regs.max_bytes > COPY_CAP) ? 9'(COPY_CAP) : regs.max_bytes;
            if (n < c)
                c = n;
            walk_copy = c;
            if (c == 0 || space_used())
            begin
                walk_phase = ctf_pkg::PH_DONE;
                return make_result(8'h00, 1'b0, 1'b1, ST_FOUND);
            end
            walk_phase = ctf_pkg::PH_COPY;
            return '0;
        end
        walk_left = n;
        walk_seen = walk_seen + 10'd1;
        if (n == 0)
            return next_tuple();
        if (space_used())
            return scan_miss();
        walk_phase = ctf_pkg::PH_SKIP;
        return '0;
    endfunction

    function automatic ctf_pkg::result_t walk_step(logic c, logic [7:0] b);
        walk_ignored = 1'b0;
        if (c == CMD_START)
        begin
            walk_pos  = '0;
            walk_seen = '0;
            walk_link = '0;
            walk_left = '0;
            walk_copy = '0;
            walk_hit  = 1'b0;
            return next_tuple();
        end
        if (walk_phase == ctf_pkg::PH_DONE || space_used())
        begin
            walk_phase   = ctf_pkg::PH_DONE;
            walk_ignored = 1'b1;
            return '0;
        end
        walk_pos = walk_pos + 16'd1;
        case (walk_phase)
            ctf_pkg::PH_TYPE:
            begin
                if (b == ctf_pkg::END_MARK || space_used())
                    return scan_miss();
                walk_hit   = (b == regs.tuple_code);
                walk_phase = ctf_pkg::PH_LINK;
                return '0;
            end
            ctf_pkg::PH_LINK:
            begin
                if (b == ctf_pkg::END_MARK)
                    return scan_miss();
                walk_link = b;
                if (regs.subtuple_enable && b > 8'd1)
                begin
                    if (space_used())
                        return scan_miss();
                    walk_phase = ctf_pkg::PH_SUB;
                    return '0;
                end
                return header_end(walk_hit && !regs.subtuple_enable, {1'b0, b});
            end
            ctf_pkg::PH_SUB:
                return header_end(walk_hit && b == regs.subtuple_code,
                                  {1'b0, walk_link - 8'd1});
            ctf_pkg::PH_SKIP:
            begin
                walk_left = walk_left - 9'd1;
                if (walk_left == 0)
                    return next_tuple();
                if (space_used())
                    return scan_miss();
                return '0;
            end
            ctf_pkg::PH_COPY:
            begin
                walk_copy = walk_copy - 9'd1;
                if (walk_copy == 0 || space_used())
                begin
                    walk_phase = ctf_pkg::PH_DONE;
                    return make_result(b, 1'b1, 1'b1, ST_FOUND);
                end
                return make_result(b, 1'b1, 1'b0, ST_FOUND);
            end
            default:
            begin
                walk_phase = ctf_pkg::PH_DONE;
                return '0;
            end
        endcase
    endfunction

    function automatic void apply_reg(logic [ctf_pkg::CFG_IDX_W-1:0] idx,
                                      logic [ctf_pkg::CFG_DATA_W-1:0] v);
        case (idx)
            ctf_pkg::REG_TUPLE_CODE:      regs.tuple_code      = v[7:0];
            ctf_pkg::REG_SUBTUPLE_ENABLE: regs.subtuple_enable = v[0];
            ctf_pkg::REG_SUBTUPLE_CODE:   regs.subtuple_code   = v[7:0];
            ctf_pkg::REG_MAX_BYTES:       regs.max_bytes       = v[8:0];
            ctf_pkg::REG_SPACE_BYTES:     regs.space_bytes     = v[15:0];
            default: ;
        endcase
    endfunction

    function automatic row_t req_row(logic c, logic [7:0] b, chk_mode_t m = CHK_MODEL,
                                     logic [7:0] eb = 8'h00, logic ev = 1'b0,
                                     logic el = 1'b0, logic es = 1'b0);
        row_t r;
        r.kind  = ROW_REQ;
        r.idx   = '0;
        r.val   = {8'h00, b};
        r.c     = c;
        r.mode  = m;
        r.fixed = {1'b1, eb, ev, el, es};
        return r;
    endfunction

    function automatic row_t cfg_row(logic [ctf_pkg::CFG_IDX_W-1:0] idx,
                                     logic [ctf_pkg::CFG_DATA_W-1:0] v);
        row_t r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.val   = v;
        r.c     = CMD_BYTE;
        r.mode  = CHK_MODEL;
        r.fixed = '0;
        return r;
    endfunction

    // scoreboard: results first, then the request taken at this edge
    always @(posedge clk)
    begin : scoreboard
        ctf_pkg::result_t want;
        ctf_pkg::result_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending.size() == 0)
                begin
                    fail_count++;
                    $error("unexpected result: body_byte %02h byte_valid %0b last %0b status %0b",
                           body_byte, byte_valid, last, status);
                end
                else
                begin
                    want = pending.pop_front();
                    if (body_byte !== want.body_byte)
                    begin
                        fail_count++;
                        $error("body_byte: expected %02h, got %02h", want.body_byte, body_byte);
                    end
                    if (byte_valid !== want.byte_valid)
                    begin
                        fail_count++;
                        $error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid);
                    end
                    if (last !== want.last)
                    begin
                        fail_count++;
                        $error("last: expected %0b, got %0b", want.last, last);
                    end
                    if (status !== want.status)
                    begin
                        fail_count++;
                        $error("status: expected %0b, got %0b", want.status, status);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pred = walk_step(cmd, card_byte);
                if (req_mode == CHK_FIXED)
                    pred = req_fixed;
                else if (req_mode == CHK_SILENT)
                    pred.emit = 1'b0;
                if (pred.emit)
                    pending.push_back(pred);
                if (!walk_ignored)
                    walk_count++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            out_stall <= 1'b1;
            stall_hold = stall_hold - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic push_request(logic c, logic [7:0] b, chk_mode_t m = CHK_MODEL,
                                ctf_pkg::result_t f = '0);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        cmd       <= c;
        card_byte <= b;
        req_mode  = m;
        req_fixed = f;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid, drain, and let the walker finish any silent request
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(logic [ctf_pkg::CFG_IDX_W-1:0] idx,
                             logic [ctf_pkg::CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(logic [15:0] tc, logic [15:0] en, logic [15:0] sc,
                                logic [15:0] mb, logic [15:0] sp);
        settle();
        write_reg(ctf_pkg::REG_TUPLE_CODE, tc);
        write_reg(ctf_pkg::REG_SUBTUPLE_ENABLE, en);
        write_reg(ctf_pkg::REG_SUBTUPLE_CODE, sc);
        write_reg(ctf_pkg::REG_MAX_BYTES, mb);
        write_reg(ctf_pkg::REG_SPACE_BYTES, sp);
    endtask

    // mostly well-formed tuple chains, with restarts and noise mixed in
    task automatic run_scan();
        logic [7:0] img[$];
        logic [7:0] ty;
        logic [7:0] ln;
        int         n_t;
        int         r;
        n_t = $urandom_range(0, 6);
        for (int t = 0; t < n_t; t++)
        begin
            if ($urandom_range(99) < 35)
                ty = regs.tuple_code;
            else
                ty = 8'($urandom_range(0, 254));
            r = $urandom_range(99);
            if (r < 5)
                ln = 8'($urandom_range(0, 255));
            else if (r < 9)
                ln = ctf_pkg::END_MARK;
            else
                ln = 8'($urandom_range(0, 10));
            img.push_back(ty);
            img.push_back(ln);
            if (ln == ctf_pkg::END_MARK)
                break;
            for (int k = 0; k < ln; k++)
            begin
                if (k == 0 && regs.subtuple_enable && $urandom_range(99) < 60)
                    img.push_back(regs.subtuple_code);
                else
                    img.push_back(8'($urandom));
            end
        end
        if ($urandom_range(99) < 80)
            img.push_back(ctf_pkg::END_MARK);
        push_request(CMD_START, 8'($urandom));
        foreach (img[i])
        begin
            if ($urandom_range(99) < 3)
                push_request(CMD_START, 8'($urandom));
            push_request(CMD_BYTE, img[i]);
        end
        if ($urandom_range(99) < 10)
        begin
            repeat ($urandom_range(1, 12))
                push_request($urandom_range(99) < 85 ? CMD_BYTE : CMD_START, 8'($urandom));
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [15:0] tc;
        logic [15:0] en;
        logic [15:0] sc;
        logic [15:0] mb;
        logic [15:0] sp;
        int          phase_no;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        cmd        = CMD_BYTE;
        card_byte  = 8'h00;
        out_stall  = 1'b0;
        fail_count = 0;
        walk_count = 0;
        gap_pct    = 0;
        stall_pct  = 0;
        stall_hold = 0;
        req_mode   = CHK_MODEL;
        req_fixed  = '0;

        regs.tuple_code      = 8'h00;
        regs.subtuple_enable = 1'b0;
        regs.subtuple_code   = 8'h00;
        regs.max_bytes       = 9'd256;
        regs.space_bytes     = 16'd0;
        walk_phase   = ctf_pkg::PH_DONE;
        walk_pos     = '0;
        walk_seen    = '0;
        walk_link    = '0;
        walk_left    = '0;
        walk_copy    = '0;
        walk_hit     = 1'b0;
        walk_ignored = 1'b0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // byte while idle, then empty space at start
        dir_rows.push_back(req_row(CMD_BYTE, 8'hFF, CHK_SILENT));
        dir_rows.push_back(req_row(CMD_START, 8'h00, CHK_FIXED, 8'h00, 1'b0, 1'b1, ST_MISS));
        dir_rows.push_back(cfg_row(ctf_pkg::REG_SPACE_BYTES, 16'hFFFF));
        dir_rows.push_back(cfg_row(ctf_pkg::REG_TUPLE_CODE, 16'h0020));
        dir_rows.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
        // skip one tuple, copy the next
        dir_rows.push_back(req_row(CMD_START, 8'hA5));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h01));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h01));
        dir_rows.push_back(req_row(CMD_BYTE, 8'hAA));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h20));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h02));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h00));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h80));
        // restart mid scan, then end mark as type
        dir_rows.push_back(req_row(CMD_START, 8'h5A));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h20));
        dir_rows.push_back(req_row(CMD_START, 8'hFF));
        dir_rows.push_back(req_row(CMD_BYTE, 8'hFF, CHK_FIXED, 8'h00, 1'b0, 1'b1, ST_MISS));
        // empty copy
        dir_rows.push_back(cfg_row(ctf_pkg::REG_MAX_BYTES, 16'h0000));
        dir_rows.push_back(req_row(CMD_START, 8'h00));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h20));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h04, CHK_FIXED, 8'h00, 1'b0, 1'b1, ST_FOUND));
        // subtype: short link never matches, then a real subtype match
        dir_rows.push_back(cfg_row(ctf_pkg::REG_MAX_BYTES, 16'h01FF));
        dir_rows.push_back(cfg_row(ctf_pkg::REG_SUBTUPLE_ENABLE, 16'h0001));
        dir_rows.push_back(cfg_row(ctf_pkg::REG_SUBTUPLE_CODE, 16'h007E));
        dir_rows.push_back(req_row(CMD_START, 8'h00));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h20));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h01));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h7E));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h20));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h02));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h7E));
        dir_rows.push_back(req_row(CMD_BYTE, 8'hFF));
        // space runs out in a header
        dir_rows.push_back(cfg_row(ctf_pkg::REG_SPACE_BYTES, 16'h0002));
        dir_rows.push_back(cfg_row(ctf_pkg::REG_SUBTUPLE_ENABLE, 16'h0000));
        dir_rows.push_back(req_row(CMD_START, 8'h00));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h01));
        dir_rows.push_back(req_row(CMD_BYTE, 8'h05, CHK_FIXED, 8'h00, 1'b0, 1'b1, ST_MISS));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
            begin
                push_request(dir_rows[i].c, dir_rows[i].val[7:0], dir_rows[i].mode,
                             dir_rows[i].fixed);
            end
        end

        // tuple limit: a long chain of empty, non-matching tuples
        program_regs(16'h003C, 16'h0000, 16'h0000, 16'd256, 16'hFFFF);
        push_request(CMD_START, 8'h00);
        repeat (WALK_LIMIT + 1)
        begin
            push_request(CMD_BYTE, 8'h01);
            push_request(CMD_BYTE, 8'h00);
        end

        // long receiver hold-off while a large body is streamed in
        settle();
        push_request(CMD_START, 8'h00);
        @(posedge clk);
        stall_hold = 300;
        push_request(CMD_BYTE, 8'h3C);
        push_request(CMD_BYTE, 8'd200);
        repeat (200) push_request(CMD_BYTE, 8'($urandom));

        settle();
        walk_count = 0;
        phase_no   = 0;
        while (walk_count < RAND_ITEMS)
        begin
            case (phase_no % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 87; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 87; end
                default: begin gap_pct = 6; stall_pct = 6; end
            endcase
            tc = 16'($urandom);
            en = 16'($urandom);
            sc = 16'($urandom);
            mb = 16'($urandom);
            case ($urandom_range(5))
                0: mb[8:0] = 9'd0;
                1: mb[8:0] = 9'd256;
                2: mb[8:0] = 9'd511;
                3: mb[8:0] = 9'($urandom_range(1, 8));
                default: mb[8:0] = 9'($urandom_range(0, 511));
            endcase
            case ($urandom_range(9))
                0: sp = 16'd0;
                1, 2, 3: sp = 16'($urandom_range(1, 40));
                4, 5, 6: sp = 16'hFFFF;
                default: sp = 16'($urandom_range(41, 400));
            endcase
            if (phase_no == 0)
            begin
                tc = 16'h0000; en = 16'h0000; sc = 16'h0000; mb = 16'h0000; sp = 16'd1;
            end
            else if (phase_no == 1)
            begin
                tc = 16'hFFFF; en = 16'hFFFF; sc = 16'hFFFF; mb = 16'hFFFF; sp = 16'hFFFF;
            end
            program_regs(tc, en, sc, mb, sp);
            repeat ($urandom_range(3, 8)) run_scan();
            phase_no++;
        end

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
